FILE: hdl/byte_round_hash_b_32_defines.svh
// Assertion macros shared by the hash block.
`ifndef BYTE_ROUND_HASH_B_32_DEFINES_SVH
`define BYTE_ROUND_HASH_B_32_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define BRH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brh assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define BRH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brh assertion failed");

`endif

FILE: hdl/brh_pkg.sv
package brh_pkg;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic            emit;
  } blk_req_t;

  localparam int NROUNDS = 16;

  localparam byte_t START_A = 8'h84;
  localparam byte_t START_B = 8'h5d;
  localparam byte_t START_C = 8'h6f;
  localparam byte_t START_D = 8'hff;

  function automatic byte_t pad_byte(input logic [1:0] idx);
    case (idx)
      2'd0: return 8'h11;
      2'd1: return 8'h89;
      2'd2: return 8'h2f;
      default: return 8'he3;
    endcase
  endfunction

  function automatic byte_t round_xor(input logic [3:0] r);
    case (r)
      4'd0: return 8'h2a;
      4'd1: return 8'h04;
      4'd2: return 8'h14;
      4'd3: return 8'h61;
      4'd4: return 8'hc4;
      4'd5: return 8'he9;
      4'd6: return 8'hf4;
      4'd7: return 8'h3e;
      4'd8: return 8'hbb;
      4'd9: return 8'ha2;
      4'd10: return 8'hb3;
      4'd11: return 8'hbc;
      4'd12: return 8'hf8;
      4'd13: return 8'h1a;
      4'd14: return 8'h3c;
      default: return 8'he4;
    endcase
  endfunction

  function automatic logic [2:0] round_rot(input logic [3:0] r);
    case (r)
      4'd0: return 3'd5;
      4'd1: return 3'd3;
      4'd2: return 3'd0;
      4'd3: return 3'd3;
      4'd4: return 3'd7;
      4'd5: return 3'd2;
      4'd6: return 3'd6;
      4'd7: return 3'd4;
      4'd8: return 3'd4;
      4'd9: return 3'd1;
      4'd10: return 3'd2;
      4'd11: return 3'd6;
      4'd12: return 3'd1;
      4'd13: return 3'd5;
      4'd14: return 3'd1;
      default: return 3'd3;
    endcase
  endfunction

  function automatic logic [1:0] byte_pick(input logic [3:0] r);
    case (r)
      4'd0: return 2'd0;
      4'd1: return 2'd1;
      4'd2: return 2'd2;
      4'd3: return 2'd3;
      4'd4: return 2'd2;
      4'd5: return 2'd3;
      4'd6: return 2'd0;
      4'd7: return 2'd1;
      4'd8: return 2'd1;
      4'd9: return 2'd0;
      4'd10: return 2'd3;
      4'd11: return 2'd2;
      4'd12: return 2'd0;
      4'd13: return 2'd3;
      4'd14: return 2'd2;
      default: return 2'd1;
    endcase
  endfunction

  function automatic byte_t rotl8(input byte_t v, input logic [2:0] n);
    logic [15:0] w;
    w = {v, v} << n;
    return w[15:8];
  endfunction

  function automatic byte_t mix(input byte_t a, input byte_t c, input logic [1:0] sel);
    case (sel)
      2'd0: return a ^ c;
      2'd1: return rotl8(a, 3'd1) + rotl8(c, 3'd7);
      2'd2: return rotl8(a, 3'd3) ^ rotl8(c, 3'd6);
      default: return a + c;
    endcase
  endfunction

endpackage

FILE: hdl/brh_queue.sv
module brh_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  brh_pkg::blk_req_t din,
  input  logic              pop,
  output brh_pkg::blk_req_t dout,
  output logic              full,
  output logic              empty
);
  import brh_pkg::*;

  blk_req_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/brh_front.sv
module brh_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              has_byte,
  input  logic              last,
  input  logic              q_full,
  output logic              push,
  output brh_pkg::blk_req_t blk
);
  import brh_pkg::*;

  byte_t      stored [4];
  logic [1:0] cnt;
  logic       accept;
  logic [2:0] fill;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && ((has_byte && (cnt == 2'd3)) || last);
  assign fill     = {1'b0, cnt} + {2'b00, has_byte};

  // merge the incoming byte, then pad the tail
  always_comb begin
    byte_t cur;
    logic [2:0] off;
    for (int p = 0; p < 4; p++) begin
      cur = (has_byte && (cnt == 2'(p))) ? data_byte : stored[p];
      off = 3'(p) - fill;
      blk.bytes[p] = (3'(p) < fill) ? cur : pad_byte(off[1:0]);
    end
    blk.emit = last;
  end

  always_ff @(posedge clk) begin
    if (accept && has_byte) begin
      stored[cnt] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (accept) begin
      if (push) begin
        cnt <= 2'd0;
      end else begin
        cnt <= fill[1:0];
      end
    end
  end

endmodule

FILE: hdl/brh_core.sv
module brh_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  brh_pkg::blk_req_t q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       digest
);
  import brh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } core_state_t;

  core_state_t state;
  blk_req_t    blk;
  logic [3:0]  rnd;
  byte_t       a, b, c, d;
  byte_t       t, b_next;
  logic        out_free;

  assign pop      = (state == S_IDLE) && !q_empty;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    t      = mix(a, c, rnd[1:0]) + blk.bytes[byte_pick(rnd)];
    b_next = rotl8(t ^ round_xor(rnd), round_rot(rnd));
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      blk <= q_data;
    end
    if (state == S_DONE && blk.emit && out_free) begin
      digest <= {a, b, c, d};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rnd       <= 4'd0;
      a         <= START_A;
      b         <= START_B;
      c         <= START_C;
      d         <= START_D;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !(state == S_DONE && blk.emit)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            rnd   <= 4'd0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          a   <= d;
          d   <= c;
          c   <= c + b;
          b   <= b_next;
          rnd <= rnd + 4'd1;
          if (rnd == 4'(NROUNDS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!blk.emit) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid <= 1'b1;
            a         <= START_A;
            b         <= START_B;
            c         <= START_C;
            d         <= START_D;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/byte_round_hash_b_32.sv
// channel | signals                          | direction
// --------+----------------------------------+----------
// in      | in_valid in_stall data_byte      | request in
//         | has_byte last                    |
// out     | out_valid out_stall digest       | request out
//
// A byte is taken whenever the block queue is not full; each 4-byte block
// (or padded tail) then passes the round unit as a load, 16 rounds and a
// finish step. The round unit works on one block at a time.
// in_stall rises only while the two-entry block queue is full; out_stall
// holds the digest register and stops the rounds only when a new digest is ready.
// rst is synchronous: start values loaded, queue and output emptied.
`include "byte_round_hash_b_32_defines.svh"

module byte_round_hash_b_32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest
);
  import brh_pkg::*;

  blk_req_t f_blk;
  blk_req_t q_data;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  brh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .last      (last),
    .q_full    (q_full),
    .push      (push),
    .blk       (f_blk)
  );

  brh_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_blk),
    .pop   (pop),
    .dout  (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  brh_core u_core (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digest    (digest)
  );

  `BRH_ASSERT_NOW(a_queue_flags, 1'b1, !(q_full && q_empty))
  `BRH_ASSERT_NOW(a_no_push_full, push, !q_full)
  `BRH_ASSERT_NOW(a_no_pop_empty, pop, !q_empty)
  `BRH_ASSERT_NEXT(a_push_not_empty, push, !q_empty)

endmodule

FILE: verif/tb.sv
module tb;
  import brh_pkg::*;

  typedef struct packed {
    byte_t a;
    byte_t b;
    byte_t c;
    byte_t d;
  } hash_regs_t;

  typedef enum logic [1:0] {
    MIX_XOR     = 2'd0,
    MIX_ROT_ADD = 2'd1,
    MIX_ROT_XOR = 2'd2,
    MIX_ADD     = 2'd3
  } mix_kind_e;

  localparam hash_regs_t HASH_INIT = '{a: START_A, b: START_B, c: START_C, d: START_D};
  localparam byte_t RND_XOR [16] = '{8'h2a, 8'h04, 8'h14, 8'h61, 8'hc4, 8'he9, 8'hf4, 8'h3e,
                                     8'hbb, 8'ha2, 8'hb3, 8'hbc, 8'hf8, 8'h1a, 8'h3c, 8'he4};
  localparam int RND_ROT [16] = '{5, 3, 0, 3, 7, 2, 6, 4, 4, 1, 2, 6, 1, 5, 1, 3};
  localparam int RND_PICK [16] = '{0, 1, 2, 3, 2, 3, 0, 1, 1, 0, 3, 2, 0, 3, 2, 1};
  localparam byte_t TAIL_PAD [4] = '{8'h11, 8'h89, 8'h2f, 8'he3};
  localparam int RANDOM_ITEMS = 850;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest;

  byte_round_hash_b_32 i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digest    (digest)
  );

  hash_regs_t  hash_st = HASH_INIT;
  byte_t       blk_buf [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
  logic [1:0]  blk_fill = 2'd0;
  logic [31:0] digest_q [$];
  int          err_count = 0;
  int          msg_items = 0;
  int          burst_left = 0;
  logic [1:0]  stall_mode = 2'd0;
  int unsigned stall_span = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL byte_round_hash_b_32");
    $finish;
  end

  function automatic byte_t rol8(byte_t v, int n);
    byte_t r;
    r = (v << (n % 8)) | (v >> (8 - (n % 8)));
    return r;
  endfunction

  function automatic byte_t mix_regs(byte_t a, byte_t c, mix_kind_e kind);
    byte_t r;
    case (kind)
      MIX_XOR:     r = a ^ c;
      MIX_ROT_ADD: r = rol8(a, 1) + rol8(c, 7);
      MIX_ROT_XOR: r = rol8(a, 3) ^ rol8(c, 6);
      default:     r = a + c;
    endcase
    return r;
  endfunction

  function automatic hash_regs_t compress_block(hash_regs_t s, byte_t blk [4]);
    hash_regs_t n;
    byte_t t;
    for (int r = 0; r < 16; r++) begin
      t = mix_regs(s.a, s.c, mix_kind_e'(r[1:0])) + blk[RND_PICK[r]];
      n.a = s.d;
      n.d = s.c;
      n.c = s.c + s.b;
      n.b = rol8(t ^ RND_XOR[r], RND_ROT[r]);
      s = n;
    end
    return s;
  endfunction

  // next-state of the hash for one accepted request; queues the digest when the request ends a message
  task automatic absorb_request(byte_t b, bit has, bit fin);
    byte_t tail [4];
    bit    done;
    done = 1'b0;
    if (has) begin
      blk_buf[blk_fill] = b;
      blk_fill = blk_fill + 2'd1;
      if (blk_fill == 2'd0) begin
        hash_st = compress_block(hash_st, blk_buf);
        done = 1'b1;
      end
    end
    if (fin) begin
      if (!done) begin
        for (int p = 0; p < 4; p++)
          tail[p] = (p < blk_fill) ? blk_buf[p] : TAIL_PAD[p - blk_fill];
        hash_st = compress_block(hash_st, tail);
      end
      digest_q.push_back(hash_st);
      hash_st = HASH_INIT;
      blk_fill = 2'd0;
    end
  endtask

  // called just after a rising edge; returns just after the accepting edge, or after a random idle gap that follows it
  task automatic send_request(byte_t b, bit has, bit fin);
    bit taken;
    int gap;
    data_byte <= b;
    has_byte  <= has;
    last      <= fin;
    in_valid  <= 1'b1;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    absorb_request(b, has, fin);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_span <= $urandom_range(20, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_span[3:0] < 4'd10);
    endcase
  end

  // outputs are stable at the falling edge; the digest is taken at the next rising edge
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest, expected none, got %h", $time, digest);
        err_count++;
      end else begin
        if (digest !== digest_q[0]) begin
          $display("%0t: digest mismatch, expected %h, got %h", $time, digest_q[0], digest);
          err_count++;
        end
        void'(digest_q.pop_front());
      end
    end
  end

  task automatic test_empty_message();
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b1);
  endtask

  task automatic test_full_block();
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h80, 1'b1, 1'b0);
    send_request(8'h7f, 1'b1, 1'b1);
  endtask

  task automatic test_padded_tails();
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h55, 1'b1, 1'b0);
    send_request(8'haa, 1'b1, 1'b1);
    send_request(8'h01, 1'b1, 1'b0);
    send_request(8'hfe, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_pad_after_full_block();
    send_request(8'h12, 1'b1, 1'b0);
    send_request(8'h34, 1'b1, 1'b0);
    send_request(8'h56, 1'b1, 1'b0);
    send_request(8'h78, 1'b1, 1'b0);
    send_request(8'hc3, 1'b0, 1'b1);
  endtask

  task automatic test_end_without_byte();
    send_request(8'h9a, 1'b1, 1'b0);
    send_request(8'h3c, 1'b0, 1'b0);
    send_request(8'hbc, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h5a, 1'b0, 1'b1);
  endtask

  task automatic test_random_messages();
    int    len;
    int    sel;
    bit    tail_end;
    byte_t b;
    while (msg_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 15)      len = 0;
      else if (sel < 80) len = $urandom_range(1, 8);
      else if (sel < 95) len = $urandom_range(9, 24);
      else               len = $urandom_range(25, 64);
      tail_end = (len == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 11) == 0)
          send_request(8'($urandom), 1'b0, 1'b0);
        sel = $urandom_range(0, 9);
        b = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hff : 8'($urandom);
        send_request(b, 1'b1, !tail_end && (i == len - 1));
        msg_items++;
      end
      if (tail_end) begin
        send_request(8'($urandom), 1'b0, 1'b1);
        msg_items++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_message();
    test_full_block();
    test_padded_tails();
    test_pad_after_full_block();
    test_end_without_byte();
    test_random_messages();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_count == 0)
      $display("PASS byte_round_hash_b_32");
    else
      $display("FAIL byte_round_hash_b_32");
    $finish;
  end

endmodule
